>>> hdl/rlc_pkg.sv
// Package: shared types, codes and sizes for the reliable link connection FSM.
package rlc_pkg;

    // Event counter width and the compare width for the long timeout check.
    localparam int COUNT_BITS = 8;
    localparam int LIMIT_W    = 8;
    localparam int CMP_W      = (COUNT_BITS + 1 > LIMIT_W) ? COUNT_BITS + 1 : LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

    // Request types on the input beat.
    localparam logic [1:0] RQ_TICK      = 2'd0;
    localparam logic [1:0] RQ_FRAME     = 2'd1;
    localparam logic [1:0] RQ_DATA_DONE = 2'd2;
    localparam logic [1:0] RQ_CONNECT   = 2'd3;

    // Received frame kinds.
    localparam logic [1:0] RX_OTHER  = 2'd0;
    localparam logic [1:0] RX_SYNACK = 2'd1;
    localparam logic [1:0] RX_ACK    = 2'd2;
    localparam logic [1:0] RX_FIN    = 2'd3;

    // Frames to transmit.
    localparam logic [1:0] FR_NONE = 2'd0;
    localparam logic [1:0] FR_SYN  = 2'd1;
    localparam logic [1:0] FR_ACK  = 2'd2;
    localparam logic [1:0] FR_FIN  = 2'd3;

    // Reported events.
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_ESTABLISHED  = 3'd1;
    localparam logic [2:0] EV_LONG_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_TORN_DOWN    = 3'd3;
    localparam logic [2:0] EV_UNEXPECTED   = 3'd4;

    // Connection states.
    typedef enum logic [2:0] {
        ST_CLOSED      = 3'd0,
        ST_SYN_SENT    = 3'd1,
        ST_PRECAUTION  = 3'd2,
        ST_ESTABLISHED = 3'd3,
        ST_FIN_SENT    = 3'd4,
        ST_AWAIT_FIN   = 3'd5,
        ST_SHORT_WAIT  = 3'd6
    } t_link_state;

    // Event class that the front end derives from one input beat.
    typedef enum logic [2:0] {
        CLS_TICK      = 3'd0,
        CLS_SYNACK    = 3'd1,
        CLS_ACK       = 3'd2,
        CLS_FIN       = 3'd3,
        CLS_OTHER     = 3'd4,
        CLS_DATA_OK   = 3'd5,
        CLS_DATA_FAIL = 3'd6,
        CLS_CONNECT   = 3'd7
    } t_cls;

    // Input beat.
    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] frame_kind;
        logic       data_ok;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic [1:0] send_frame;
        logic [2:0] event_code;
        logic [2:0] conn_state;
    } t_out_item;

    // Queue handshake between front and back.
    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_q_beat;

endpackage

>>> hdl/rlc_front.sv
// Front end: classifies input beats and buffers them in a two-entry queue.
module rlc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rlc_pkg::t_in_item  i_in_data,
    output rlc_pkg::t_q_beat   o_q,
    input  logic               i_q_ready
);

    rlc_pkg::t_cls w_cls;
    rlc_pkg::t_cls r_q_data [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic          w_push;
    logic          w_pop;

    // Decode the request and frame kind into one event class.
    always_comb begin
        unique case (i_in_data.req_type)
            rlc_pkg::RQ_TICK:      w_cls = rlc_pkg::CLS_TICK;
            rlc_pkg::RQ_DATA_DONE: w_cls = i_in_data.data_ok ? rlc_pkg::CLS_DATA_OK
                                                              : rlc_pkg::CLS_DATA_FAIL;
            rlc_pkg::RQ_CONNECT:   w_cls = rlc_pkg::CLS_CONNECT;
            default: begin
                unique case (i_in_data.frame_kind)
                    rlc_pkg::RX_SYNACK: w_cls = rlc_pkg::CLS_SYNACK;
                    rlc_pkg::RX_ACK:    w_cls = rlc_pkg::CLS_ACK;
                    rlc_pkg::RX_FIN:    w_cls = rlc_pkg::CLS_FIN;
                    default:            w_cls = rlc_pkg::CLS_OTHER;
                endcase
            end
        endcase
    end

    // Queue control.
    assign o_in_ready = (r_count != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q.valid && i_q_ready;
    assign o_q.valid  = (r_count != 2'd0);
    assign o_q.cls    = r_q_data[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    // Pointer and fill registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_data[r_wr_ptr] <= w_cls;
        end
    end

endmodule

>>> hdl/rlc_back.sv
// Back end: connection state machine, wait counter, limit register and result register.
module rlc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rlc_pkg::t_q_beat   i_q,
    output logic               o_q_ready,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rlc_pkg::t_out_item o_out_data
);

    rlc_pkg::t_link_state             r_state, n_state;
    logic [rlc_pkg::COUNT_BITS-1:0]   r_count, n_count;
    logic [rlc_pkg::LIMIT_W-1:0]      r_limit;
    logic                             r_out_valid, n_out_valid;
    rlc_pkg::t_out_item               r_out_data, n_out_data;

    logic                             w_take;
    logic                             w_counted;
    logic                             w_moved;
    logic [1:0]                       w_send;
    logic [2:0]                       w_event;
    rlc_pkg::t_link_state             w_step_state;
    logic [rlc_pkg::CMP_W-1:0]        w_inc;
    logic [rlc_pkg::CMP_W-1:0]        w_lim;
    logic [rlc_pkg::CMP_W-1:0]        w_cap;
    logic                             w_expired;

    assign o_cfg_ready = 1'b1;
    assign w_take      = i_q.valid && (!r_out_valid || i_out_ready);
    assign o_q_ready   = (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Effective limit: zero acts as one, clipped to the counter range.
    always_comb begin
        w_cap = rlc_pkg::CMP_W'(1) << rlc_pkg::COUNT_BITS;
        w_lim = rlc_pkg::CMP_W'(r_limit);
        if (w_lim == '0) begin
            w_lim = rlc_pkg::CMP_W'(1);
        end
        if (w_lim > w_cap) begin
            w_lim = w_cap;
        end
        w_inc     = rlc_pkg::CMP_W'(r_count) + rlc_pkg::CMP_W'(1);
        w_expired = (w_inc >= w_lim);
    end

    // Transition decode for the event at the head of the queue.
    always_comb begin
        w_send       = rlc_pkg::FR_NONE;
        w_event      = rlc_pkg::EV_NONE;
        w_counted    = 1'b0;
        w_moved      = 1'b0;
        w_step_state = r_state;
        unique case (r_state)
            rlc_pkg::ST_SYN_SENT: begin
                unique case (i_q.cls)
                    rlc_pkg::CLS_TICK: begin
                        w_send    = rlc_pkg::FR_SYN;
                        w_counted = 1'b1;
                    end
                    rlc_pkg::CLS_SYNACK: begin
                        w_send       = rlc_pkg::FR_ACK;
                        w_step_state = rlc_pkg::ST_PRECAUTION;
                        w_moved      = 1'b1;
                    end
                    rlc_pkg::CLS_ACK, rlc_pkg::CLS_FIN, rlc_pkg::CLS_OTHER: begin
                        w_event   = rlc_pkg::EV_UNEXPECTED;
                        w_counted = 1'b1;
                    end
                    default: ;
                endcase
            end
            rlc_pkg::ST_PRECAUTION: begin
                unique case (i_q.cls)
                    rlc_pkg::CLS_TICK: begin
                        w_event      = rlc_pkg::EV_ESTABLISHED;
                        w_step_state = rlc_pkg::ST_ESTABLISHED;
                        w_moved      = 1'b1;
                    end
                    rlc_pkg::CLS_SYNACK: begin
                        w_send    = rlc_pkg::FR_ACK;
                        w_counted = 1'b1;
                    end
                    rlc_pkg::CLS_ACK, rlc_pkg::CLS_FIN, rlc_pkg::CLS_OTHER: begin
                        w_event   = rlc_pkg::EV_UNEXPECTED;
                        w_counted = 1'b1;
                    end
                    default: ;
                endcase
            end
            rlc_pkg::ST_ESTABLISHED: begin
                unique case (i_q.cls)
                    rlc_pkg::CLS_DATA_OK: begin
                        w_send       = rlc_pkg::FR_FIN;
                        w_step_state = rlc_pkg::ST_FIN_SENT;
                        w_moved      = 1'b1;
                    end
                    rlc_pkg::CLS_DATA_FAIL: begin
                        w_event      = rlc_pkg::EV_LONG_TIMEOUT;
                        w_step_state = rlc_pkg::ST_CLOSED;
                        w_moved      = 1'b1;
                    end
                    default: ;
                endcase
            end
            rlc_pkg::ST_FIN_SENT: begin
                unique case (i_q.cls)
                    rlc_pkg::CLS_TICK: begin
                        w_send    = rlc_pkg::FR_FIN;
                        w_counted = 1'b1;
                    end
                    rlc_pkg::CLS_ACK: begin
                        w_step_state = rlc_pkg::ST_AWAIT_FIN;
                        w_moved      = 1'b1;
                    end
                    rlc_pkg::CLS_SYNACK, rlc_pkg::CLS_FIN, rlc_pkg::CLS_OTHER: begin
                        w_event   = rlc_pkg::EV_UNEXPECTED;
                        w_counted = 1'b1;
                    end
                    default: ;
                endcase
            end
            rlc_pkg::ST_AWAIT_FIN: begin
                unique case (i_q.cls)
                    rlc_pkg::CLS_TICK: begin
                        w_counted = 1'b1;
                    end
                    rlc_pkg::CLS_FIN: begin
                        w_send       = rlc_pkg::FR_ACK;
                        w_step_state = rlc_pkg::ST_SHORT_WAIT;
                        w_moved      = 1'b1;
                    end
                    rlc_pkg::CLS_SYNACK, rlc_pkg::CLS_ACK, rlc_pkg::CLS_OTHER: begin
                        w_event   = rlc_pkg::EV_UNEXPECTED;
                        w_counted = 1'b1;
                    end
                    default: ;
                endcase
            end
            rlc_pkg::ST_SHORT_WAIT: begin
                if (i_q.cls == rlc_pkg::CLS_TICK) begin
                    w_event      = rlc_pkg::EV_TORN_DOWN;
                    w_step_state = rlc_pkg::ST_CLOSED;
                    w_moved      = 1'b1;
                end
            end
            default: begin
                // Closed, and any unknown encoding treated as closed.
                if (i_q.cls == rlc_pkg::CLS_CONNECT) begin
                    w_send       = rlc_pkg::FR_SYN;
                    w_step_state = rlc_pkg::ST_SYN_SENT;
                    w_moved      = 1'b1;
                end else begin
                    w_step_state = rlc_pkg::ST_CLOSED;
                end
            end
        endcase
    end

    // Next state, wait count and result register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_take) begin
            n_state = w_step_state;
            n_out_data.send_frame = w_send;
            n_out_data.event_code = w_event;
            if (w_moved) begin
                n_count = '0;
            end else if (w_counted) begin
                if (w_expired) begin
                    n_state = rlc_pkg::ST_CLOSED;
                    n_count = '0;
                    n_out_data.event_code = rlc_pkg::EV_LONG_TIMEOUT;
                end else begin
                    n_count = w_inc[rlc_pkg::COUNT_BITS-1:0];
                end
            end
            n_out_data.conn_state = n_state;
            n_out_valid = 1'b1;
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlc_pkg::ST_CLOSED;
            r_count     <= '0;
            r_limit     <= rlc_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

>>> hdl/reliable_link_connection_fsm.sv
// Top level: client connection state machine for a reliable link.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one event per
// beat: a short timeout tick, a received frame, the end of the data phase or
// a connect request. Output channel (o_out_valid / i_out_ready / o_out_data)
// returns exactly one result beat per event: the frame to send, an event code
// and the new connection state. The configuration channel (i_cfg_valid /
// o_cfg_ready / i_cfg_data) writes the long timeout limit and is always ready.
// An accepted event is written to the queue and then registered in the result
// register, from which the receiver takes it. One event per cycle is sustained
// while the receiver takes each result. A two-entry queue separates the
// classifier from the state machine, and the result register takes the next
// event in the same cycle that the receiver takes the previous result. When
// the receiver stalls, the result holds, the queue fills and o_in_ready drops
// once the queue holds two events. Synchronous reset puts the link in the
// closed state, clears the wait counter and sets the limit to ten.
module reliable_link_connection_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rlc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rlc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    rlc_pkg::t_q_beat w_q;
    logic             w_q_ready;

    // Classifier and event queue.
    rlc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q        (w_q),
        .i_q_ready  (w_q_ready)
    );

    // State machine and result register.
    rlc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (w_q),
        .o_q_ready   (w_q_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
